// ===== hdl/sag_pkg.sv =====
// Shared types and constants of the strided tensor address generator.
`default_nettype none
package sag_pkg;

  localparam int NUM_AXES_DEF   = 4;
  localparam int COORD_BITS_DEF = 16;
  localparam int LANE_BITS      = 16;
  localparam int WORD_BITS      = 64;
  localparam int OUT_TDATA_BITS = 136;
  localparam int CFG_IDX_BITS   = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_SHAPE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_CORNER = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_CORNER   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_STRIDES      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_ORDER   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_BEFORE   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_AFTER    = 3'd6;

  localparam logic [7:0] AXIS_ORDER_RESET = 8'hE4;

  typedef enum logic [1:0] {
    KIND_TRANSLATE = 2'd0,
    KIND_ITERATE   = 2'd1,
    KIND_PAST_END  = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic       last;
    logic       in_extent;
  } item_flags_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic empty;
  } derive_status_t;

endpackage
`default_nettype wire

// ===== hdl/sag_derive.sv =====
// Configuration registers and the sequencer that derives target extents and row pitches.
`default_nettype none
module sag_derive import sag_pkg::*; #(
  parameter int N   = NUM_AXES_DEF,
  parameter int CB  = COORD_BITS_DEF,
  parameter int AXW = (N > 1) ? $clog2(N) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_valid,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [WORD_BITS-1:0]    cfg_data,
  output logic      [CB-1:0]           shape   [N],
  output logic      [CB-1:0]           start   [N],
  output logic      [CB-1:0]           pad_bef [N],
  output logic      [CB-1:0]           stride  [N],
  output logic      [AXW-1:0]          axis_map[N],
  output logic      [CB-1:0]           extent  [N],
  output logic      [WORD_BITS-1:0]    pitch   [N],
  output derive_status_t               status
);

  localparam int BCW = $clog2(CB + 2);

  typedef enum logic [4:0] {
    D_IDLE  = 5'b00001,
    D_LOAD  = 5'b00010,
    D_DIV   = 5'b00100,
    D_PLOAD = 5'b01000,
    D_PMUL  = 5'b10000
  } dstate_t;

  dstate_t              state;
  logic [CB-1:0]        end_r   [N];
  logic [CB-1:0]        stride_r[N];
  logic [7:0]           order_r;
  logic [AXW-1:0]       ax;
  logic [BCW-1:0]       bc;
  logic [CB:0]          num;
  logic [CB-1:0]        rem;
  logic [CB:0]          quo;
  logic [CB-1:0]        dsor;
  logic [CB-1:0]        mplr;
  logic [WORD_BITS-1:0] prod;
  logic [WORD_BITS-1:0] acc;
  logic                 empty;
  logic                 done;
  logic                 wr;

  logic [AXW-1:0]       s_ax;
  logic [CB-1:0]        diff;
  logic [CB:0]          num_load;
  logic [CB:0]          rem_sh;
  logic                 ge;
  logic [CB:0]          rem_n;
  logic [CB:0]          quo_n;
  logic [WORD_BITS-1:0] acc_n;

  assign wr = cfg_valid && (cfg_index <= REG_PAD_AFTER);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      logic [1:0] sel;
      sel = order_r[2*i +: 2];
      axis_map[i] = (int'(sel) < N) ? AXW'(sel) : AXW'(i);
      stride[i]   = (stride_r[i] == '0) ? CB'(1) : stride_r[i];
    end
  end

  // ceil(d / stride) as floor((d + stride - 1) / stride), one quotient bit a cycle
  assign s_ax     = axis_map[ax];
  assign diff     = (end_r[s_ax] > start[s_ax]) ? (end_r[s_ax] - start[s_ax]) : '0;
  assign num_load = {1'b0, diff} + {1'b0, stride[s_ax]} - (CB+1)'(1);
  assign rem_sh   = {rem, num[CB]};
  assign ge       = rem_sh >= {1'b0, dsor};
  assign rem_n    = ge ? (rem_sh - {1'b0, dsor}) : rem_sh;
  assign quo_n    = {quo[CB-1:0], ge};
  assign acc_n    = {acc[WORD_BITS-2:0], 1'b0} + (mplr[CB-1] ? prod : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        shape[i]    <= '0;
        start[i]    <= '0;
        end_r[i]    <= '0;
        stride_r[i] <= CB'(1);
        pad_bef[i]  <= '0;
      end
      order_r <= AXIS_ORDER_RESET;
      state   <= D_LOAD;
      ax      <= '0;
      empty   <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (wr) begin
        unique case (cfg_index)
          REG_SOURCE_SHAPE: for (int i = 0; i < N; i++) shape[i] <= cfg_data[LANE_BITS*i +: CB];
          REG_START_CORNER: for (int i = 0; i < N; i++) start[i] <= cfg_data[LANE_BITS*i +: CB];
          REG_END_CORNER:   for (int i = 0; i < N; i++) end_r[i] <= cfg_data[LANE_BITS*i +: CB];
          REG_STRIDES:      for (int i = 0; i < N; i++) stride_r[i] <= cfg_data[LANE_BITS*i +: CB];
          REG_AXIS_ORDER:   order_r <= cfg_data[7:0];
          REG_PAD_BEFORE:   for (int i = 0; i < N; i++) pad_bef[i] <= cfg_data[LANE_BITS*i +: CB];
          default: ;
        endcase
        state <= D_LOAD;
        ax    <= '0;
        empty <= 1'b0;
      end else begin
        unique case (state)
          D_IDLE: ;
          D_LOAD: begin
            num   <= num_load;
            dsor  <= stride[s_ax];
            rem   <= '0;
            quo   <= '0;
            bc    <= '0;
            state <= D_DIV;
          end
          D_DIV: begin
            rem <= rem_n[CB-1:0];
            quo <= quo_n;
            num <= {num[CB-1:0], 1'b0};
            bc  <= bc + BCW'(1);
            if (bc == BCW'(CB)) begin
              extent[ax] <= quo_n[CB-1:0];
              if (quo_n == '0) empty <= 1'b1;
              if (ax == AXW'(N-1)) begin
                prod  <= WORD_BITS'(1);
                state <= D_PLOAD;
              end else begin
                ax    <= ax + AXW'(1);
                state <= D_LOAD;
              end
            end
          end
          D_PLOAD: begin
            pitch[ax] <= prod;
            acc       <= '0;
            mplr      <= shape[ax];
            bc        <= '0;
            state     <= D_PMUL;
          end
          D_PMUL: begin
            acc  <= acc_n;
            mplr <= {mplr[CB-2:0], 1'b0};
            bc   <= bc + BCW'(1);
            if (bc == BCW'(CB-1)) begin
              prod <= acc_n;
              if (ax == '0) begin
                done  <= 1'b1;
                state <= D_IDLE;
              end else begin
                ax    <= ax - AXW'(1);
                state <= D_PLOAD;
              end
            end
          end
          default: state <= D_IDLE;
        endcase
      end
    end
  end

  assign status.busy  = (state != D_IDLE);
  assign status.done  = done;
  assign status.empty = empty;

endmodule
`default_nettype wire

// ===== hdl/sag_front.sv =====
// Front end: accepts requests, runs the odometer and classifies each transaction.
`default_nettype none
module sag_front import sag_pkg::*; #(
  parameter int N  = NUM_AXES_DEF,
  parameter int CB = COORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 opcode,
  input  wire logic [WORD_BITS-1:0] query,
  input  wire derive_status_t       status,
  input  wire logic [CB-1:0]        extent[N],
  input  wire logic                 q_full,
  output logic                      push,
  output logic      [N*CB-1:0]      push_coord,
  output item_flags_t               push_flags
);

  logic [CB-1:0] iter[N];
  logic          past_end;
  logic [CB-1:0] nxt [N];
  logic [CB-1:0] crd [N];
  logic          wrap[N];
  logic          cin [N];
  logic          all_wrap;
  logic          in_extent;

  // hold off while derivation runs, while the iterator restarts after it, and while the queue is full
  assign in_ready = !status.busy && !status.done && !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    for (int i = 0; i < N; i++)
      wrap[i] = ({1'b0, iter[i]} + (CB+1)'(1)) >= {1'b0, extent[i]};
    // last axis runs fastest; carry ripples towards axis 0
    cin[N-1] = 1'b1;
    for (int i = N - 1; i > 0; i--)
      cin[i-1] = cin[i] && wrap[i];
    all_wrap = cin[0] && wrap[0];
    in_extent = 1'b1;
    for (int i = 0; i < N; i++) begin
      nxt[i] = cin[i] ? (wrap[i] ? '0 : iter[i] + CB'(1)) : iter[i];
      crd[i] = opcode ? query[LANE_BITS*i +: CB] : iter[i];
      if (crd[i] >= extent[i]) in_extent = 1'b0;
      push_coord[CB*i +: CB] = crd[i];
    end
    push_flags.in_extent = in_extent;
    push_flags.last      = 1'b0;
    if (opcode) begin
      push_flags.kind = KIND_TRANSLATE;
    end else if (past_end) begin
      push_flags.kind = KIND_PAST_END;
    end else begin
      push_flags.kind = KIND_ITERATE;
      push_flags.last = all_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) iter[i] <= '0;
      past_end <= 1'b1;
    end else if (status.done) begin
      for (int i = 0; i < N; i++) iter[i] <= '0;
      past_end <= status.empty;
    end else if (push && !opcode) begin
      if (past_end) begin
        for (int i = 0; i < N; i++) iter[i] <= '0;
        past_end <= status.empty;
      end else begin
        for (int i = 0; i < N; i++) iter[i] <= nxt[i];
        if (all_wrap) past_end <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sag_queue.sv =====
// Two-entry queue between the front end and the address engine.
`default_nettype none
module sag_queue import sag_pkg::*; #(
  parameter int W = NUM_AXES_DEF * COORD_BITS_DEF + $bits(item_flags_t)
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  input  wire logic         pop,
  output logic      [W-1:0] rdata,
  output logic              full,
  output logic              empty
);

  logic [W-1:0] mem[2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sag_back.sv =====
// Address engine: source coordinates, padding check and row-major index on a shared multiplier.
`default_nettype none
module sag_back import sag_pkg::*; #(
  parameter int N   = NUM_AXES_DEF,
  parameter int CB  = COORD_BITS_DEF,
  parameter int AXW = (N > 1) ? $clog2(N) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_empty,
  input  wire logic [N*CB-1:0]      q_coord,
  input  wire item_flags_t          q_flags,
  output logic                      pop,
  input  wire logic [CB-1:0]        shape   [N],
  input  wire logic [CB-1:0]        start   [N],
  input  wire logic [CB-1:0]        pad_bef [N],
  input  wire logic [CB-1:0]        stride  [N],
  input  wire logic [AXW-1:0]       axis_map[N],
  input  wire logic [WORD_BITS-1:0] pitch   [N],
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [WORD_BITS-1:0] target_coord,
  output logic      [WORD_BITS-1:0] source_index,
  output logic                      padding_hit,
  output logic                      within_target,
  output logic                      past_end,
  output logic                      last_coord
);

  localparam int POSW = 2 * CB + 1;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_POSM = 6'b000010,
    B_POSA = 6'b000100,
    B_IDXM = 6'b001000,
    B_IDXA = 6'b010000,
    B_DONE = 6'b100000
  } bstate_t;

  bstate_t              state;
  logic [CB-1:0]        coord[N];
  item_flags_t          flags;
  logic [AXW-1:0]       ax;
  logic [1:0]           part;
  logic [WORD_BITS-1:0] src[N];
  logic                 pad;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] prod;

  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [WORD_BITS-1:0] mul_p;
  logic [AXW-1:0]       s_ax;
  logic [POSW-1:0]      pos;
  logic [CB:0]          lim;
  logic [WORD_BITS-1:0] tc;

  assign pop  = (state == B_IDLE) && !q_empty;
  assign s_ax = axis_map[ax];
  assign pos  = POSW'(prod[2*CB-1:0]) + POSW'(start[s_ax]);
  assign lim  = {1'b0, pad_bef[s_ax]} + {1'b0, shape[s_ax]};

  // 64-bit product modulo 2^64 from three 32x32 partial products
  always_comb begin
    if (state == B_POSM) begin
      mul_a = 32'(coord[ax]);
      mul_b = 32'(stride[s_ax]);
    end else begin
      unique case (part)
        2'd0:    begin mul_a = src[ax][31:0];  mul_b = pitch[ax][31:0];  end
        2'd1:    begin mul_a = src[ax][31:0];  mul_b = pitch[ax][63:32]; end
        default: begin mul_a = src[ax][63:32]; mul_b = pitch[ax][31:0];  end
      endcase
    end
    mul_p = mul_a * mul_b;
    tc = '0;
    for (int i = 0; i < N; i++) tc[LANE_BITS*i +: CB] = coord[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != B_DONE) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            for (int i = 0; i < N; i++) begin
              coord[i] <= q_coord[CB*i +: CB];
              src[i]   <= '0;
            end
            flags <= q_flags;
            pad   <= 1'b0;
            acc   <= '0;
            ax    <= '0;
            part  <= 2'd0;
            state <= (q_flags.kind == KIND_PAST_END) ? B_DONE : B_POSM;
          end
        end
        B_POSM: begin
          prod  <= mul_p;
          state <= B_POSA;
        end
        B_POSA: begin
          if (pos < POSW'(pad_bef[s_ax]) || pos >= POSW'(lim)) pad <= 1'b1;
          src[s_ax] <= WORD_BITS'(pos) - WORD_BITS'(pad_bef[s_ax]);
          if (ax == AXW'(N-1)) begin
            ax    <= '0;
            state <= B_IDXM;
          end else begin
            ax    <= ax + AXW'(1);
            state <= B_POSM;
          end
        end
        B_IDXM: begin
          prod  <= mul_p;
          state <= B_IDXA;
        end
        B_IDXA: begin
          acc <= acc + ((part == 2'd0) ? prod : {prod[31:0], 32'd0});
          if (part == 2'd2) begin
            part <= 2'd0;
            if (ax == AXW'(N-1)) begin
              state <= B_DONE;
            end else begin
              ax    <= ax + AXW'(1);
              state <= B_IDXM;
            end
          end else begin
            part  <= part + 2'd1;
            state <= B_IDXM;
          end
        end
        B_DONE: begin
          // hold the result until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            if (flags.kind == KIND_PAST_END) begin
              target_coord  <= '0;
              source_index  <= '0;
              padding_hit   <= 1'b0;
              within_target <= 1'b0;
              past_end      <= 1'b1;
              last_coord    <= 1'b0;
            end else begin
              target_coord  <= tc;
              source_index  <= acc;
              padding_hit   <= pad;
              within_target <= flags.in_extent;
              past_end      <= 1'b0;
              last_coord    <= flags.last;
            end
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/strided_tensor_address_generator.sv =====
// A translate or iterate transaction passes through the shared 32x32 multiplier: one pass per axis for
// the source position, then three per axis for the index; a past-end transaction skips it.
// The engine takes the next transaction from the queue only once it has passed on the last one.
// After reset and each configuration write s_tready stays low until extents and pitches are
// derived again; reset is synchronous, active high.
`default_nettype none
module strided_tensor_address_generator import sag_pkg::*; #(
  parameter int NUM_AXES   = NUM_AXES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [WORD_BITS-1:0]      s_tdata,  // query_coord
  input  wire logic                      s_tuser,  // opcode
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // target_coord, source_index, padding_hit, within_target, zero fill
  output logic      [OUT_TDATA_BITS-1:0] m_tdata,
  output logic                           m_tuser,  // past_end
  output logic                           m_tlast,  // last_coord
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [WORD_BITS-1:0]      cfg_data
);

  localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int CW  = NUM_AXES * COORD_BITS;
  localparam int QW  = CW + $bits(item_flags_t);

  logic [COORD_BITS-1:0] shape   [NUM_AXES];
  logic [COORD_BITS-1:0] start   [NUM_AXES];
  logic [COORD_BITS-1:0] pad_bef [NUM_AXES];
  logic [COORD_BITS-1:0] stride  [NUM_AXES];
  logic [AXW-1:0]        axis_map[NUM_AXES];
  logic [COORD_BITS-1:0] extent  [NUM_AXES];
  logic [WORD_BITS-1:0]  pitch   [NUM_AXES];
  derive_status_t        status;

  logic                  q_push;
  logic [CW-1:0]         push_coord;
  item_flags_t           push_flags;
  logic                  q_pop;
  logic [QW-1:0]         q_rdata;
  logic                  q_full;
  logic                  q_empty;

  logic [WORD_BITS-1:0]  target_coord;
  logic [WORD_BITS-1:0]  source_index;
  logic                  padding_hit;
  logic                  within_target;

  assign cfg_ready = 1'b1;

  sag_derive #(.N(NUM_AXES), .CB(COORD_BITS), .AXW(AXW)) u_derive (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data,
    .shape, .start, .pad_bef, .stride, .axis_map, .extent, .pitch, .status
  );

  sag_front #(.N(NUM_AXES), .CB(COORD_BITS)) u_front (
    .clk, .rst,
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .opcode   (s_tuser),
    .query    (s_tdata),
    .status,
    .extent,
    .q_full,
    .push     (q_push),
    .push_coord,
    .push_flags
  );

  sag_queue #(.W(QW)) u_queue (
    .clk, .rst,
    .push  (q_push),
    .wdata ({push_flags, push_coord}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  sag_back #(.N(NUM_AXES), .CB(COORD_BITS), .AXW(AXW)) u_back (
    .clk, .rst,
    .q_empty,
    .q_coord   (q_rdata[CW-1:0]),
    .q_flags   (item_flags_t'(q_rdata[QW-1:CW])),
    .pop       (q_pop),
    .shape, .start, .pad_bef, .stride, .axis_map, .pitch,
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .target_coord,
    .source_index,
    .padding_hit,
    .within_target,
    .past_end  (m_tuser),
    .last_coord(m_tlast)
  );

  assign m_tdata = {6'd0, within_target, padding_hit, source_index, target_coord};

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !s_tready)
    else $error("request accepted while derivation runs");

  a_past_end_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0 && !m_tlast))
    else $error("past-end result carries data");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue written while full");

endmodule
`default_nettype wire
